@@ src/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition in one cycle brings a result in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pcd_pkg.sv @@
// Types, constants and microcode table of the phase-control dimmer.
package pcd_pkg;

   localparam int CNT_W       = 16;
   localparam int BRIGHT_W    = 7;
   localparam int X_W         = 23;
   localparam int MUL_B_W     = 16;
   localparam int PROD_W      = X_W + MUL_B_W;
   localparam int UPC_W       = 5;
   localparam int RECIP_SHIFT = 22;

   localparam logic [MUL_B_W-1:0]  RECIP_100   = 16'd41943;
   localparam logic [MUL_B_W-1:0]  DIV_100     = 16'd100;
   localparam logic [MUL_B_W-1:0]  COMP_PCT    = 16'd30;
   localparam logic [MUL_B_W-1:0]  REST_PCT    = 16'd70;
   localparam logic [CNT_W-1:0]    UNIT_MARGIN = 16'd2;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 7'd100;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_ZCROSS = 2'd1,
      OP_RAMP   = 2'd2,
      OP_SET    = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [BRIGHT_W-1:0] brightness_value;
   } req_type;

   typedef struct packed {
      logic                drive_level;
      logic [CNT_W-1:0]    measured_period;
      logic [CNT_W-1:0]    pulse_length_now;
      logic [BRIGHT_W-1:0] last_brightness;
   } rsp_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_TICK,
      UOP_ZCROSS,
      UOP_RAMP,
      UOP_LOAD_PERIOD,
      UOP_MUL_RECIP,
      UOP_QUOT_EST,
      UOP_MUL_Q100,
      UOP_QUOT_FIX,
      UOP_UNIT,
      UOP_MUL_30,
      UOP_BASE,
      UOP_MUL_70,
      UOP_LOAD_PROD,
      UOP_MUL_BRIGHT,
      UOP_TARGET
   } uop_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_DISPATCH,
      SEQ_EMIT
   } seq_type;

   typedef logic [UPC_W-1:0] upc_type;

   typedef struct packed {
      uop_type uop;
      seq_type seq;
      upc_type target;
   } uword_type;

   typedef struct packed {
      uop_type uop;
      logic    load_item;
      logic    emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic                drive_level;
      logic                pulse_armed;
      logic [CNT_W-1:0]    period_latched;
      logic [CNT_W-1:0]    pulse_length;
      logic [BRIGHT_W-1:0] brightness_record;
   } dp_status_type;

   localparam upc_type A_IDLE = 5'd0;
   localparam upc_type A_TICK = 5'd1;
   localparam upc_type A_ZC   = 5'd2;
   localparam upc_type A_RAMP = 5'd3;
   localparam upc_type A_SET  = 5'd4;
   localparam upc_type A_EMIT = 5'd20;

   function automatic uword_type urom(upc_type addr);
      uword_type w;
      w = '{uop: UOP_NOP, seq: SEQ_GOTO, target: A_IDLE};
      case (addr)
         5'd0:  w = '{uop: UOP_NOP,         seq: SEQ_DISPATCH, target: A_IDLE};
         5'd1:  w = '{uop: UOP_TICK,        seq: SEQ_GOTO,     target: A_EMIT};
         5'd2:  w = '{uop: UOP_ZCROSS,      seq: SEQ_GOTO,     target: A_EMIT};
         5'd3:  w = '{uop: UOP_RAMP,        seq: SEQ_GOTO,     target: A_EMIT};
         5'd4:  w = '{uop: UOP_LOAD_PERIOD, seq: SEQ_NEXT,     target: A_IDLE};
         5'd5:  w = '{uop: UOP_MUL_RECIP,   seq: SEQ_NEXT,     target: A_IDLE};
         5'd6:  w = '{uop: UOP_QUOT_EST,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd7:  w = '{uop: UOP_MUL_Q100,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd8:  w = '{uop: UOP_QUOT_FIX,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd9:  w = '{uop: UOP_UNIT,        seq: SEQ_NEXT,     target: A_IDLE};
         5'd10: w = '{uop: UOP_MUL_30,      seq: SEQ_NEXT,     target: A_IDLE};
         5'd11: w = '{uop: UOP_BASE,        seq: SEQ_NEXT,     target: A_IDLE};
         5'd12: w = '{uop: UOP_MUL_70,      seq: SEQ_NEXT,     target: A_IDLE};
         5'd13: w = '{uop: UOP_LOAD_PROD,   seq: SEQ_NEXT,     target: A_IDLE};
         5'd14: w = '{uop: UOP_MUL_RECIP,   seq: SEQ_NEXT,     target: A_IDLE};
         5'd15: w = '{uop: UOP_QUOT_EST,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd16: w = '{uop: UOP_MUL_Q100,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd17: w = '{uop: UOP_QUOT_FIX,    seq: SEQ_NEXT,     target: A_IDLE};
         5'd18: w = '{uop: UOP_MUL_BRIGHT,  seq: SEQ_NEXT,     target: A_IDLE};
         5'd19: w = '{uop: UOP_TARGET,      seq: SEQ_GOTO,     target: A_EMIT};
         5'd20: w = '{uop: UOP_NOP,         seq: SEQ_EMIT,     target: A_IDLE};
         default: w = '{uop: UOP_NOP,       seq: SEQ_GOTO,     target: A_IDLE};
      endcase
      return w;
   endfunction

   function automatic upc_type entry_addr(opcode_type op, logic enabled);
      upc_type a;
      a = A_EMIT;
      case (op)
         OP_TICK:   a = enabled ? A_TICK : A_EMIT;
         OP_ZCROSS: a = A_ZC;
         OP_RAMP:   a = A_RAMP;
         OP_SET:    a = enabled ? A_SET : A_EMIT;
         default:   a = A_EMIT;
      endcase
      return a;
   endfunction

endpackage

@@ src/phase_control_dimmer_top.sv @@
// Top level of the phase-control dimmer: handshakes, result register, control register.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data  (req_type)
//   rsp      out        rsp_valid / rsp_ready   rsp_data  (rsp_type)
//   csr      in         csr_we                  csr_wdata (dimmer enable)
//
// Tick, zero crossing and ramp step run one micro-operation and then the emit step; a new item
// is taken only once the sequencer is back idle. Set brightness runs a 16-step microcode program:
// two divisions by 100 through the one shared multiplier, then the emit step.
// A disabled tick or set brightness goes straight to the emit step.
// Synchronous reset; the enable register comes out of reset set.
// A waiting rsp result holds the sequencer in its emit step until that register is free.
module phase_control_dimmer_top import pcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

`include "assert_macros.svh"

   logic          enabled_ff, enabled_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          idle;
   logic          start;
   logic          out_free;
   dp_ctrl_type   ctrl;
   dp_status_type status;

   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pcd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .opcode   (req_data.opcode),
      .enabled  (enabled_ff),
      .out_free (out_free),
      .ctrl     (ctrl),
      .idle     (idle)
   );

   pcd_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (req_data),
      .status (status)
   );

   always_comb begin
      enabled_in   = csr_we ? csr_wdata : enabled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.emit) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.drive_level      = status.drive_level;
         rsp_data_in.measured_period  = status.period_latched;
         rsp_data_in.pulse_length_now = status.pulse_length;
         rsp_data_in.last_brightness  = status.brightness_record;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready,
      "sequencer still idle after accepting an item")
   `ASSERT_ALWAYS(a_emit_slot_free, clock, reset, !ctrl.emit || !rsp_valid_ff || rsp_ready,
      "result written over a waiting result")
   `ASSERT_ALWAYS(a_drive_needs_armed, clock, reset, !status.drive_level || status.pulse_armed,
      "drive high without an armed pulse")

endmodule

@@ src/pcd_seq.sv @@
// Microcode sequencer: step counter, control word fetch and jumps.
module pcd_seq import pcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  opcode_type  opcode,
   input  logic        enabled,
   input  logic        out_free,
   output dp_ctrl_type ctrl,
   output logic        idle
);

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type word;

   always_comb begin
      word   = urom(upc_ff);
      upc_in = upc_ff;
      case (word.seq)
         SEQ_NEXT:     upc_in = upc_type'(upc_ff + 1'b1);
         SEQ_GOTO:     upc_in = word.target;
         SEQ_DISPATCH: if (start) upc_in = entry_addr(opcode, enabled);
         SEQ_EMIT:     if (out_free) upc_in = word.target;
         default:      upc_in = A_IDLE;
      endcase
      ctrl.uop       = word.uop;
      ctrl.load_item = start;
      ctrl.emit      = (word.seq == SEQ_EMIT) && out_free;
      idle           = (word.seq == SEQ_DISPATCH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= A_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ src/pcd_datapath.sv @@
// Dimmer state registers, shared multiplier and micro-operation logic.
module pcd_datapath import pcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_ctrl_type   ctrl,
   input  req_type       item,
   output dp_status_type status
);

   logic [CNT_W-1:0]    period_counter_ff, period_counter_in;
   logic [CNT_W-1:0]    period_latched_ff, period_latched_in;
   logic                pulse_armed_ff, pulse_armed_in;
   logic [CNT_W-1:0]    pulse_counter_ff, pulse_counter_in;
   logic [CNT_W-1:0]    pulse_length_ff, pulse_length_in;
   logic [CNT_W-1:0]    target_length_ff, target_length_in;
   logic                output_level_ff, output_level_in;
   logic [BRIGHT_W-1:0] brightness_record_ff, brightness_record_in;

   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [CNT_W-1:0]    q_ff, q_in;
   logic [PROD_W-1:0]   p_ff, p_in;
   logic [CNT_W-1:0]    unit_ff, unit_in;
   logic [CNT_W-1:0]    base_ff, base_in;

   logic [X_W-1:0]      mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [CNT_W-1:0]    cnt_inc;
   logic [X_W:0]        rem;

   always_comb begin
      mul_a = x_ff;
      mul_b = RECIP_100;
      case (ctrl.uop)
         UOP_MUL_Q100: begin
            mul_a = X_W'(q_ff);
            mul_b = DIV_100;
         end
         UOP_MUL_30: begin
            mul_a = X_W'(unit_ff);
            mul_b = COMP_PCT;
         end
         UOP_MUL_70: begin
            mul_a = X_W'(unit_ff);
            mul_b = REST_PCT;
         end
         UOP_MUL_BRIGHT: begin
            mul_a = X_W'(q_ff);
            mul_b = MUL_B_W'(bright_ff);
         end
         default: begin
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      period_counter_in    = period_counter_ff;
      period_latched_in    = period_latched_ff;
      pulse_armed_in       = pulse_armed_ff;
      pulse_counter_in     = pulse_counter_ff;
      pulse_length_in      = pulse_length_ff;
      target_length_in     = target_length_ff;
      output_level_in      = output_level_ff;
      brightness_record_in = brightness_record_ff;
      bright_in            = ctrl.load_item ? item.brightness_value : bright_ff;
      x_in                 = x_ff;
      q_in                 = q_ff;
      p_in                 = p_ff;
      unit_in              = unit_ff;
      base_in              = base_ff;
      cnt_inc              = CNT_W'(pulse_counter_ff + 1'b1);
      rem                  = {1'b0, x_ff} - {1'b0, p_ff[X_W-1:0]};

      case (ctrl.uop)
         UOP_TICK: begin
            period_counter_in = CNT_W'(period_counter_ff + 1'b1);
            if (pulse_armed_ff) begin
               if (cnt_inc < pulse_length_ff) begin
                  pulse_counter_in = cnt_inc;
                  output_level_in  = 1'b1;
               end else begin
                  pulse_counter_in = '0;
                  pulse_armed_in   = 1'b0;
                  output_level_in  = 1'b0;
               end
            end else begin
               output_level_in = 1'b0;
            end
         end
         UOP_ZCROSS: begin
            period_latched_in = period_counter_ff;
            period_counter_in = '0;
            pulse_armed_in    = 1'b1;
         end
         UOP_RAMP: begin
            if (pulse_length_ff < target_length_ff) begin
               pulse_length_in = CNT_W'(pulse_length_ff + 1'b1);
            end else if (pulse_length_ff > target_length_ff) begin
               pulse_length_in = CNT_W'(pulse_length_ff - 1'b1);
            end
         end
         UOP_LOAD_PERIOD: begin
            x_in = X_W'(period_latched_ff);
            if (bright_ff != '0) brightness_record_in = bright_ff;
         end
         UOP_MUL_RECIP: begin
            p_in = mul_p;
         end
         UOP_QUOT_EST: begin
            q_in = p_ff[RECIP_SHIFT +: CNT_W];
         end
         UOP_MUL_Q100: begin
            p_in = mul_p;
         end
         UOP_QUOT_FIX: begin
            if (rem >= (X_W+1)'(DIV_100)) q_in = CNT_W'(q_ff + 1'b1);
         end
         UOP_UNIT: begin
            unit_in = CNT_W'(q_ff - UNIT_MARGIN);
         end
         UOP_MUL_30: begin
            p_in = mul_p;
         end
         UOP_BASE: begin
            base_in = p_ff[CNT_W-1:0];
         end
         UOP_MUL_70: begin
            p_in = mul_p;
         end
         UOP_LOAD_PROD: begin
            x_in = p_ff[X_W-1:0];
         end
         UOP_MUL_BRIGHT: begin
            p_in = mul_p;
         end
         UOP_TARGET: begin
            if (bright_ff == '0) begin
               target_length_in = '0;
            end else begin
               target_length_in = CNT_W'(base_ff + p_ff[CNT_W-1:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_counter_ff    <= '0;
         period_latched_ff    <= '0;
         pulse_armed_ff       <= 1'b0;
         pulse_counter_ff     <= '0;
         pulse_length_ff      <= '0;
         target_length_ff     <= '0;
         output_level_ff      <= 1'b0;
         brightness_record_ff <= BRIGHT_MAX;
      end else begin
         period_counter_ff    <= period_counter_in;
         period_latched_ff    <= period_latched_in;
         pulse_armed_ff       <= pulse_armed_in;
         pulse_counter_ff     <= pulse_counter_in;
         pulse_length_ff      <= pulse_length_in;
         target_length_ff     <= target_length_in;
         output_level_ff      <= output_level_in;
         brightness_record_ff <= brightness_record_in;
      end
   end

   always_ff @(posedge clock) begin
      bright_ff <= bright_in;
      x_ff      <= x_in;
      q_ff      <= q_in;
      p_ff      <= p_in;
      unit_ff   <= unit_in;
      base_ff   <= base_in;
   end

   assign status.drive_level       = output_level_ff;
   assign status.pulse_armed       = pulse_armed_ff;
   assign status.period_latched    = period_latched_ff;
   assign status.pulse_length      = pulse_length_ff;
   assign status.brightness_record = brightness_record_ff;

endmodule
